// ===== src/pfs_pkg.sv =====
// shared types and constants of the pareto front store
`default_nettype none
package pfs_pkg;
    localparam int AREA_W  = 24;
    localparam int DELAY_W = 16;
    localparam int LEVEL_W = 16;
    localparam int TOL_W   = 16;
    localparam int KEEP_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_PRUNE  = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // relation of the new point to a stored point
    typedef enum logic [2:0] {
        REL_BEFORE,
        REL_AFTER,
        REL_NEW_WINS,
        REL_OLD_WINS,
        REL_EQUAL
    } t_rel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_DIV,
        ST_RD,
        ST_EV,
        ST_PUT,
        ST_APP,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [DELAY_W-1:0] delay;
        logic [LEVEL_W-1:0] level;
    } t_point;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic rd;
        logic wr_old;
        logic wr_new;
        logic adv;
        logic commit;
        logic clr;
        logic flag_acc;
        logic flag_ovf;
        logic pick;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        t_rel  rel;
        logic  hit;
        logic  last;
        logic  empty;
        logic  div_done;
        logic  ovf_before;
        logic  ovf_app;
        logic  prune_skip;
        logic  keep_pt;
        logic  placed;
    } t_st;
endpackage
`default_nettype wire

// ===== src/pareto_front_store.sv =====
// pareto front store top level: sequencer, datapath and checks
//
// keeps an area-delay pareto curve of up to CURVE_DEPTH points sorted by rising
// area and falling delay. an operation (insert, query, prune, clear) is taken
// when start is high and busy is low; its single result appears on the o_ ports
// for exactly one cycle with o_done high and cannot be held off, so capture it
// then. every stored point visited passes through the one memory read port in
// a read state, then an evaluate state. an insert that lands before a stored
// point writes that point in a put state in place of the append state, and a
// prune that is not skipped first runs a bit-serial division. clear, a skipped
// prune and a query on an empty curve visit no stored point. busy is low again
// in the result cycle, so the next transfer may come then. the area tolerance
// register is written through the cfg channel, which is always ready; write it
// only while the block is idle. curve storage needs no clearing after reset:
// only entries below the point count are ever read.
`default_nettype none
module pareto_front_store import pfs_pkg::*; #(
    parameter int CURVE_DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [1:0]                       i_mode,
    input  wire  [AREA_W-1:0]                i_area_value,
    input  wire  [DELAY_W-1:0]               i_delay_value,
    input  wire  [LEVEL_W-1:0]               i_level_value,
    input  wire  [DELAY_W-1:0]               i_target_delay,
    input  wire  [KEEP_W-1:0]                i_keep_count,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [TOL_W-1:0]                 i_cfg_data,
    output logic                             o_done,
    output logic [AREA_W-1:0]                o_out_area,
    output logic [DELAY_W-1:0]               o_out_delay,
    output logic [LEVEL_W-1:0]               o_out_level,
    output logic                             o_meets_target,
    output logic                             o_curve_empty,
    output logic [$clog2(CURVE_DEPTH+1)-1:0] o_point_count,
    output logic                             o_accepted,
    output logic                             o_overflow
);
    t_cmd cmd;
    t_st  st;

    // the user must issue tolerance writes only while idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;

    pfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    pfs_dp #(.CURVE_DEPTH(CURVE_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_mode         (i_mode),
        .i_area_value   (i_area_value),
        .i_delay_value  (i_delay_value),
        .i_level_value  (i_level_value),
        .i_target_delay (i_target_delay),
        .i_keep_count   (i_keep_count),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_area     (o_out_area),
        .o_out_delay    (o_out_delay),
        .o_out_level    (o_out_level),
        .o_meets_target (o_meets_target),
        .o_curve_empty  (o_curve_empty),
        .o_point_count  (o_point_count),
        .o_accepted     (o_accepted),
        .o_overflow     (o_overflow),
        .o_done         (o_done)
    );

    // an accepted operation keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after operation transfer");

    // result strobe lasts one cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // kept and overflow exclude each other
    a_acc_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_accepted && o_overflow))
        else $error("insert both kept and dropped");

    // curve never grows past its depth, empty flag agrees with count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_point_count <= ($clog2(CURVE_DEPTH+1))'(CURVE_DEPTH))
                   && (o_curve_empty == (o_point_count == '0)))
        else $error("point count out of range");
endmodule
`default_nettype wire

// ===== src/pfs_ctrl.sv =====
// operation sequencer of the pareto front store
`default_nettype none
module pfs_ctrl import pfs_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_st  i_st,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_st.mode)
                    MODE_INSERT: n_state = i_st.empty ? ST_APP : ST_RD;
                    MODE_QUERY:  n_state = i_st.empty ? ST_DONE : ST_RD;
                    MODE_PRUNE:  n_state = i_st.prune_skip ? ST_DONE : ST_DIV;
                    MODE_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_DIV: begin
                if (i_st.div_done) begin
                    n_state = ST_RD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EV;
            end
            ST_EV: begin
                unique case (i_st.mode)
                    MODE_INSERT: begin
                        if (i_st.placed) begin
                            o_cmd.wr_old = 1'b1;
                            o_cmd.adv    = 1'b1;
                            n_state      = i_st.last ? ST_COMMIT : ST_RD;
                        end else begin
                            unique case (i_st.rel)
                                REL_OLD_WINS, REL_EQUAL: n_state = ST_DONE;
                                REL_NEW_WINS: begin
                                    o_cmd.adv = 1'b1;
                                    n_state   = i_st.last ? ST_APP : ST_RD;
                                end
                                REL_AFTER: begin
                                    o_cmd.wr_old = 1'b1;
                                    o_cmd.adv    = 1'b1;
                                    n_state      = i_st.last ? ST_APP : ST_RD;
                                end
                                REL_BEFORE: begin
                                    if (i_st.ovf_before) begin
                                        o_cmd.flag_ovf = 1'b1;
                                        n_state        = ST_DONE;
                                    end else begin
                                        o_cmd.wr_new = 1'b1;
                                        n_state      = ST_PUT;
                                    end
                                end
                                default: n_state = ST_DONE;
                            endcase
                        end
                    end
                    MODE_QUERY: begin
                        o_cmd.pick = 1'b1;
                        if (i_st.hit || i_st.last) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.adv = 1'b1;
                            n_state   = ST_RD;
                        end
                    end
                    MODE_PRUNE: begin
                        o_cmd.wr_old = i_st.keep_pt;
                        o_cmd.adv    = 1'b1;
                        n_state      = i_st.last ? ST_COMMIT : ST_RD;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_PUT: begin
                o_cmd.wr_old = 1'b1;
                o_cmd.adv    = 1'b1;
                n_state      = i_st.last ? ST_COMMIT : ST_RD;
            end
            ST_APP: begin
                if (i_st.ovf_app) begin
                    o_cmd.flag_ovf = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit   = 1'b1;
                o_cmd.flag_acc = (i_st.mode == MODE_INSERT);
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/pfs_dp.sv =====
// point store, scan registers, divider and result registers
`default_nettype none
module pfs_dp import pfs_pkg::*; #(
    parameter int CURVE_DEPTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  t_cmd                           i_cmd,
    output t_st                            o_st,
    input  wire  [1:0]                     i_mode,
    input  wire  [AREA_W-1:0]              i_area_value,
    input  wire  [DELAY_W-1:0]             i_delay_value,
    input  wire  [LEVEL_W-1:0]             i_level_value,
    input  wire  [DELAY_W-1:0]             i_target_delay,
    input  wire  [KEEP_W-1:0]              i_keep_count,
    input  wire                            i_cfg_wr,
    input  wire  [TOL_W-1:0]               i_cfg_data,
    output logic [AREA_W-1:0]              o_out_area,
    output logic [DELAY_W-1:0]             o_out_delay,
    output logic [LEVEL_W-1:0]             o_out_level,
    output logic                           o_meets_target,
    output logic                           o_curve_empty,
    output logic [$clog2(CURVE_DEPTH+1)-1:0] o_point_count,
    output logic                           o_accepted,
    output logic                           o_overflow,
    output logic                           o_done
);
    localparam int CW  = $clog2(CURVE_DEPTH + 1);
    localparam int IW  = $clog2(CURVE_DEPTH);
    localparam int SW  = CW + 1;
    localparam int DCW = $clog2(CW + 1);
    localparam int MW  = CW + KEEP_W;

    // two banks: one holds the curve, the other receives the rewritten one
    t_point mem [0:2*(2**IW)-1];

    logic [CW-1:0]      r_count, r_i, r_nk, r_quo;
    logic               r_bank, r_placed;
    logic [TOL_W-1:0]   r_tol;
    t_mode              r_mode;
    t_point             r_new, r_rd, r_q;
    logic [DELAY_W-1:0] r_tgt;
    logic [KEEP_W-1:0]  r_keep, r_rem;
    logic [DCW-1:0]     r_dcnt;
    logic [SW-1:0]      r_m;
    logic               r_qmeet, r_acc, r_ovf;
    logic               r_done;

    logic [SW-1:0]       step, m_inc, room;
    logic [KEEP_W:0]     trial_in, trial;
    logic                lt, gt;
    logic [AREA_W-1:0]   diff_ns, diff_sn;
    t_rel                rel;
    logic [IW:0]         rd_addr, wr_addr;
    t_point              wr_data;

    // area compare within tolerance, delays exact
    always_comb begin
        diff_sn = r_rd.area - r_new.area;
        diff_ns = r_new.area - r_rd.area;
        lt = (r_rd.area > r_new.area) && (diff_sn > AREA_W'(r_tol));
        gt = (r_new.area > r_rd.area) && (diff_ns > AREA_W'(r_tol));
        priority if (lt) begin
            rel = (r_new.delay <= r_rd.delay) ? REL_NEW_WINS : REL_BEFORE;
        end else if (!gt) begin
            if (r_new.delay == r_rd.delay) begin
                rel = REL_EQUAL;
            end else begin
                rel = (r_new.delay < r_rd.delay) ? REL_NEW_WINS : REL_OLD_WINS;
            end
        end else begin
            rel = (r_new.delay < r_rd.delay) ? REL_AFTER : REL_OLD_WINS;
        end
    end

    always_comb begin
        step     = {1'b0, r_quo} + SW'(1);
        m_inc    = r_m + SW'(1);
        room     = {1'b0, r_nk} + ({1'b0, r_count} - {1'b0, r_i});
        trial_in = {r_rem, r_quo[CW-1]};
        trial    = trial_in - {1'b0, r_keep};
        rd_addr  = {r_bank, r_i[IW-1:0]};
        wr_addr  = {~r_bank, r_nk[IW-1:0]};
        wr_data  = i_cmd.wr_new ? r_new : r_rd;

        o_st.mode       = r_mode;
        o_st.rel        = rel;
        o_st.hit        = (r_rd.delay <= r_tgt);
        o_st.last       = ({1'b0, r_i} + SW'(1)) == {1'b0, r_count};
        o_st.empty      = (r_count == '0);
        o_st.div_done   = (r_dcnt == DCW'(CW));
        o_st.ovf_before = room >= SW'(CURVE_DEPTH);
        o_st.ovf_app    = (r_nk == CW'(CURVE_DEPTH));
        o_st.prune_skip = (r_keep == '0) || (MW'(r_count) < MW'(r_keep));
        o_st.keep_pt    = (r_i == '0) || o_st.last || (r_m == '0);
        o_st.placed     = r_placed;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[rd_addr];
        end
        if (i_cmd.wr_old || i_cmd.wr_new) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
            r_tol   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cfg_wr) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_count <= '0;
            end
            if (i_cmd.commit) begin
                r_count <= r_nk;
                r_bank  <= ~r_bank;
            end
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode    <= t_mode'(i_mode);
            r_new     <= '{area: i_area_value, delay: i_delay_value, level: i_level_value};
            r_tgt     <= i_target_delay;
            r_keep    <= i_keep_count;
            r_i       <= '0;
            r_nk      <= '0;
            r_m       <= '0;
            r_placed  <= 1'b0;
            r_quo     <= r_count;
            r_rem     <= '0;
            r_dcnt    <= '0;
            r_q       <= '0;
            r_qmeet   <= 1'b0;
            r_acc     <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCW'(1);
                if (!trial[KEEP_W]) begin
                    r_rem <= trial[KEEP_W-1:0];
                    r_quo <= {r_quo[CW-2:0], 1'b1};
                end else begin
                    r_rem <= trial_in[KEEP_W-1:0];
                    r_quo <= {r_quo[CW-2:0], 1'b0};
                end
            end
            if (i_cmd.wr_old || i_cmd.wr_new) begin
                r_nk <= r_nk + CW'(1);
            end
            if (i_cmd.wr_new) begin
                r_placed <= 1'b1;
            end
            if (i_cmd.adv) begin
                r_i <= r_i + CW'(1);
                r_m <= (m_inc == step) ? '0 : m_inc;
            end
            if (i_cmd.pick) begin
                r_q     <= r_rd;
                r_qmeet <= o_st.hit;
            end
            if (i_cmd.flag_acc) begin
                r_acc <= 1'b1;
            end
            if (i_cmd.flag_ovf) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // result registers, loaded once per operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_area     <= (r_mode == MODE_QUERY) ? r_q.area : '0;
            o_out_delay    <= (r_mode == MODE_QUERY) ? r_q.delay : '0;
            o_out_level    <= (r_mode == MODE_QUERY) ? r_q.level : '0;
            o_meets_target <= (r_mode == MODE_QUERY) && r_qmeet;
            o_curve_empty  <= (r_count == '0);
            o_point_count  <= r_count;
            o_accepted     <= r_acc;
            o_overflow     <= r_ovf;
        end
    end
endmodule
`default_nettype wire
